// ===== hdl/dpf_pkg.sv =====
// shared types, constants and a helper function of the duplicate packet filter
package dpf_pkg;

	localparam int DEFAULT_CHANNELS = 64;
	localparam int DEFAULT_DEPTH    = 128;

	localparam int CHAN_W  = 6;
	localparam int TIME_W  = 62;
	localparam int RATE_W  = 16;
	localparam int COUNT_W = 16;
	localparam int CAP_W   = 8;
	localparam int STAT_W  = 4;
	localparam int TOL_W   = 14;
	localparam int WIN_W   = 64;

	localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

	localparam logic [RATE_W-1:0] RATE_CLASS_A = 16'd105;
	localparam logic [RATE_W-1:0] RATE_CLASS_B = 16'd255;
	localparam logic [RATE_W-1:0] RATE_CLASS_C = 16'd505;
	localparam logic [RATE_W-1:0] RATE_CLASS_D = 16'd1005;

	localparam logic [TOL_W-1:0] TOL_A = 14'd15000;
	localparam logic [TOL_W-1:0] TOL_B = 14'd4500;
	localparam logic [TOL_W-1:0] TOL_C = 14'd2500;
	localparam logic [TOL_W-1:0] TOL_D = 14'd1500;

	typedef enum logic [STAT_W-1:0] {
		STS_FIRST     = 4'd0,
		STS_APPENDED  = 4'd1,
		STS_PREPENDED = 4'd2,
		STS_TOO_OLD   = 4'd3,
		STS_BACKFILL  = 4'd4,
		STS_DUPLICATE = 4'd5,
		STS_SLIP      = 4'd6,
		STS_EMPTY     = 4'd7,
		STS_MISMATCH  = 4'd8,
		STS_UNCLASS   = 4'd9
	} status_t;

	typedef struct packed {
		logic [TIME_W-1:0]  t_start;
		logic [TIME_W-1:0]  t_end;
		logic [COUNT_W-1:0] samples;
	} entry_t;

	// zero means the rate has no class
	function automatic logic [TOL_W-1:0] tolerance(input logic [RATE_W-1:0] rate);
		logic [TOL_W-1:0] tol;
		if (rate < RATE_CLASS_A) tol = TOL_A;
		else if (rate < RATE_CLASS_B) tol = TOL_B;
		else if (rate < RATE_CLASS_C) tol = TOL_C;
		else if (rate < RATE_CLASS_D) tol = TOL_D;
		else tol = '0;
		return tol;
	endfunction

endpackage

// ===== hdl/dpf_if.sv =====
// request and result channel interfaces
interface dpf_pkt_if;
	logic                         valid;
	logic                         ready;
	logic [dpf_pkg::CHAN_W-1:0]   channel;
	logic [dpf_pkg::TIME_W-1:0]   start_time;
	logic [dpf_pkg::TIME_W-1:0]   end_time;
	logic [dpf_pkg::RATE_W-1:0]   sample_rate;
	logic [dpf_pkg::COUNT_W-1:0]  sample_count;

	modport source(output valid, channel, start_time, end_time, sample_rate, sample_count,
		input ready);
	modport sink(input valid, channel, start_time, end_time, sample_rate, sample_count,
		output ready);
endinterface

interface dpf_res_if;
	logic                        valid;
	logic                        ready;
	logic                        allowed;
	logic [dpf_pkg::STAT_W-1:0]  status;

	modport source(output valid, allowed, status, input ready);
	modport sink(input valid, allowed, status, output ready);
endinterface

// ===== hdl/dpf_ram.sv =====
// simple dual-port memory with registered read
module dpf_ram #(
	parameter int WIDTH  = 8,
	parameter int WORDS  = 2,
	parameter int ADDR_W = 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [WORDS];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hdl/dpf_ctrl.sv =====
// sequencer: channel lookup, header scan, row shifts and insertion sort
module dpf_ctrl #(
	parameter int CHANNELS = dpf_pkg::DEFAULT_CHANNELS,
	parameter int DEPTH    = dpf_pkg::DEFAULT_DEPTH,
	parameter int CW       = 1,
	parameter int FW       = 1,
	parameter int AW       = 1,
	parameter int TW       = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [FW-1:0]         cap,
	input  logic [CW-1:0]         ch_idx,
	dpf_pkt_if.sink               pkt,
	dpf_res_if.source             res,
	output logic                  ent_we,
	output logic [AW-1:0]         ent_waddr,
	output dpf_pkg::entry_t       ent_wdata,
	output logic [AW-1:0]         ent_raddr,
	input  dpf_pkg::entry_t       ent_rdata,
	output logic                  chn_we,
	output logic [CW-1:0]         chn_waddr,
	output logic [TW-1:0]         chn_wdata,
	output logic [CW-1:0]         chn_raddr,
	input  logic [TW-1:0]         chn_rdata
);
	import dpf_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_CH_DEC, ST_SCAN, ST_DECIDE, ST_MV_RD, ST_MV_WR,
		ST_PUT_NEW, ST_SR_RD, ST_SR_KEY, ST_SR_CMP, ST_SR_PUT, ST_FIN, ST_RESP
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        ch_q;
	logic [CW-1:0]        clr_q;
	logic [AW-1:0]        base_q;
	logic [TIME_W-1:0]    st_q;
	logic [TIME_W-1:0]    en_q;
	logic [RATE_W-1:0]    rate_q;
	logic [COUNT_W-1:0]   cnt_q;
	logic [WIN_W-1:0]     win_lo_q;
	logic [WIN_W-1:0]     win_hi_q;
	logic                 unclass_q;
	logic [FW-1:0]        n_q;
	logic [FW-1:0]        i_q;
	logic [FW-1:0]        j_q;
	logic [FW-1:0]        m_q;
	logic [FW-1:0]        new_pos_q;
	logic [FW-1:0]        mv_src_q;
	logic [FW-1:0]        mv_dst_q;
	logic [FW-1:0]        mv_left_q;
	logic                 mv_up_q;
	logic                 sort_q;
	logic [TIME_W-1:0]    first_start_q;
	logic [TIME_W-1:0]    last_end_q;
	logic                 slip_q;
	entry_t               key_q;
	logic                 allowed_q;
	status_t              status_q;
	logic                 res_valid_q;
	logic                 res_allowed_q;
	status_t              res_status_q;

	logic                 seen;
	logic [RATE_W-1:0]    stored_rate;
	logic [FW-1:0]        stored_fill;
	logic [TOL_W-1:0]     in_tol;
	logic                 in_window;
	logic                 dup_hit;
	logic                 slip_hit;
	logic                 accept;
	logic                 res_free;
	logic [FW-1:0]        keep;
	entry_t               new_entry;

	function automatic logic [AW-1:0] ea(input logic [AW-1:0] base, input logic [FW-1:0] idx);
		return base + AW'(idx);
	endfunction

	assign seen        = chn_rdata[TW-1];
	assign stored_rate = chn_rdata[FW +: RATE_W];
	assign stored_fill = chn_rdata[FW-1:0];
	assign in_tol      = tolerance(pkt.sample_rate);
	assign accept      = pkt.valid && pkt.ready;
	assign res_free    = !res_valid_q || res.ready;
	assign new_entry   = '{t_start: st_q, t_end: en_q, samples: cnt_q};

	assign in_window = ($signed(WIN_W'(ent_rdata.t_start)) > $signed(win_lo_q))
		&& (WIN_W'(ent_rdata.t_start) < win_hi_q);
	assign dup_hit   = (ent_rdata.samples == cnt_q) && (unclass_q || in_window);
	assign slip_hit  = (st_q >= ent_rdata.t_start && st_q <= ent_rdata.t_end)
		|| (en_q >= ent_rdata.t_start && en_q <= ent_rdata.t_end);
	assign keep      = (n_q >= cap) ? FW'(cap - FW'(1)) : n_q;

	assign pkt.ready   = (state_q == ST_IDLE);
	assign res.valid   = res_valid_q;
	assign res.allowed = res_allowed_q;
	assign res.status  = res_status_q;

	// memory ports
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = base_q;
		ent_wdata = new_entry;
		ent_raddr = base_q;
		chn_we    = 1'b0;
		chn_waddr = ch_q;
		chn_wdata = {1'b1, rate_q, m_q};
		chn_raddr = ch_idx;
		unique case (state_q)
			ST_CLEAR: begin
				chn_we    = 1'b1;
				chn_waddr = clr_q;
				chn_wdata = '0;
			end
			ST_CH_DEC: begin
				if (cnt_q != '0 && !seen) begin
					chn_we    = 1'b1;
					chn_wdata = {1'b1, rate_q, FW'(1)};
					ent_we    = 1'b1;
				end
			end
			ST_SCAN: ent_raddr = ea(base_q, FW'(i_q + FW'(1)));
			ST_MV_RD: ent_raddr = ea(base_q, mv_src_q);
			ST_MV_WR: begin
				ent_we    = 1'b1;
				ent_waddr = ea(base_q, mv_dst_q);
				ent_wdata = ent_rdata;
			end
			ST_PUT_NEW: begin
				ent_we    = 1'b1;
				ent_waddr = ea(base_q, new_pos_q);
			end
			ST_SR_RD: ent_raddr = ea(base_q, i_q);
			ST_SR_KEY: ent_raddr = ea(base_q, FW'(i_q - FW'(1)));
			ST_SR_CMP: begin
				ent_raddr = ea(base_q, FW'(j_q - FW'(2)));
				if (ent_rdata.t_start > key_q.t_start) begin
					ent_we    = 1'b1;
					ent_waddr = ea(base_q, j_q);
					ent_wdata = ent_rdata;
				end
			end
			ST_SR_PUT: begin
				ent_we    = 1'b1;
				ent_waddr = ea(base_q, j_q);
				ent_wdata = key_q;
			end
			ST_FIN: chn_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			res_valid_q   <= 1'b0;
			res_allowed_q <= 1'b0;
			res_status_q  <= STS_FIRST;
		end else begin
			if (res.ready && !(state_q == ST_RESP && res_free)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= CW'(clr_q + CW'(1));
					if (clr_q == CW'(CHANNELS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						ch_q      <= ch_idx;
						base_q    <= AW'(AW'(ch_idx) * AW'(DEPTH));
						st_q      <= pkt.start_time;
						en_q      <= pkt.end_time;
						rate_q    <= pkt.sample_rate;
						cnt_q     <= pkt.sample_count;
						win_lo_q  <= WIN_W'(pkt.start_time) - WIN_W'(in_tol);
						win_hi_q  <= WIN_W'(pkt.start_time) + WIN_W'(in_tol);
						unclass_q <= (in_tol == '0);
						state_q   <= ST_CH_DEC;
					end
				end
				ST_CH_DEC: begin
					n_q    <= stored_fill;
					i_q    <= '0;
					slip_q <= 1'b0;
					priority if (cnt_q == '0) begin
						allowed_q <= 1'b0;
						status_q  <= STS_EMPTY;
						state_q   <= ST_RESP;
					end else if (!seen) begin
						allowed_q <= 1'b1;
						status_q  <= STS_FIRST;
						state_q   <= ST_RESP;
					end else if (stored_rate != rate_q) begin
						allowed_q <= 1'b1;
						status_q  <= STS_MISMATCH;
						state_q   <= ST_RESP;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (dup_hit) begin
						allowed_q <= unclass_q;
						status_q  <= unclass_q ? STS_UNCLASS : STS_DUPLICATE;
						state_q   <= ST_RESP;
					end else begin
						if (i_q == '0) begin
							first_start_q <= ent_rdata.t_start;
						end
						last_end_q <= ent_rdata.t_end;
						slip_q     <= slip_q || slip_hit;
						i_q        <= FW'(i_q + FW'(1));
						if (i_q == FW'(n_q - FW'(1))) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					mv_up_q <= 1'b0;
					priority if (st_q > last_end_q || (en_q >= first_start_q && !slip_q)) begin
						allowed_q <= 1'b1;
						status_q  <= (st_q > last_end_q) ? STS_APPENDED : STS_BACKFILL;
						sort_q    <= !(st_q > last_end_q);
						new_pos_q <= keep;
						m_q       <= FW'(keep + FW'(1));
						mv_src_q  <= FW'(n_q - keep);
						mv_dst_q  <= '0;
						mv_left_q <= keep;
						state_q   <= (keep == n_q || keep == '0) ? ST_PUT_NEW : ST_MV_RD;
					end else if (en_q < first_start_q) begin
						allowed_q <= 1'b1;
						if (n_q < cap) begin
							status_q  <= STS_PREPENDED;
							sort_q    <= 1'b0;
							new_pos_q <= '0;
							m_q       <= FW'(n_q + FW'(1));
							mv_up_q   <= 1'b1;
							mv_src_q  <= FW'(n_q - FW'(1));
							mv_dst_q  <= n_q;
							mv_left_q <= n_q;
							state_q   <= ST_MV_RD;
						end else begin
							status_q <= STS_TOO_OLD;
							state_q  <= ST_RESP;
						end
					end else begin
						allowed_q <= 1'b0;
						status_q  <= STS_SLIP;
						state_q   <= ST_RESP;
					end
				end
				ST_MV_RD: state_q <= ST_MV_WR;
				ST_MV_WR: begin
					mv_left_q <= FW'(mv_left_q - FW'(1));
					mv_src_q  <= mv_up_q ? FW'(mv_src_q - FW'(1)) : FW'(mv_src_q + FW'(1));
					mv_dst_q  <= mv_up_q ? FW'(mv_dst_q - FW'(1)) : FW'(mv_dst_q + FW'(1));
					state_q   <= (mv_left_q == FW'(1)) ? ST_PUT_NEW : ST_MV_RD;
				end
				ST_PUT_NEW: begin
					i_q     <= FW'(1);
					state_q <= (sort_q && m_q > FW'(1)) ? ST_SR_RD : ST_FIN;
				end
				ST_SR_RD: state_q <= ST_SR_KEY;
				ST_SR_KEY: begin
					key_q   <= ent_rdata;
					j_q     <= i_q;
					state_q <= ST_SR_CMP;
				end
				ST_SR_CMP: begin
					if (ent_rdata.t_start > key_q.t_start) begin
						j_q <= FW'(j_q - FW'(1));
						if (j_q == FW'(1)) begin
							state_q <= ST_SR_PUT;
						end
					end else begin
						state_q <= ST_SR_PUT;
					end
				end
				ST_SR_PUT: begin
					i_q     <= FW'(i_q + FW'(1));
					state_q <= (FW'(i_q + FW'(1)) < m_q) ? ST_SR_RD : ST_FIN;
				end
				ST_FIN: state_q <= ST_RESP;
				ST_RESP: begin
					if (res_free) begin
						res_valid_q   <= 1'b1;
						res_allowed_q <= allowed_q;
						res_status_q  <= status_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_accept_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_CH_DEC)
		else $error("accepted request did not start a channel lookup");

	a_fill_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> m_q != '0 && m_q <= cap)
		else $error("stored count out of range");

	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECIDE |-> n_q != '0 && 32'(n_q) <= DEPTH)
		else $error("scanned row count out of range");

	a_result_post: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESP && res_free |=> res.valid && state_q == ST_IDLE)
		else $error("result not posted");
endmodule

// ===== hdl/duplicate_packet_filter_core.sv =====
// duplicate packet filter top level: capacity register, channel map and memories
//
// Requests arrive on pkt (valid/ready), one packet header each; every request
// gives exactly one result on res (allowed, status), in request order.
// The capacity register is written through cfg_we/cfg_wdata while idle; the
// block itself does not enforce this, the user must keep to it.
// pkt.ready is high only while the sequencer is idle; one request at a time.
// A request rejected before the scan goes from the channel lookup straight
// to its result. Otherwise the scan reads each stored header of its channel
// (n headers, up to DEPTH); headers are then moved, a read and a write each,
// on append or backfill with drop or on prepend, and a backfill then runs an
// insertion sort of the row. All of this runs through the single header
// memory port pair. After reset the channel table is cleared, one channel per
// cycle, and no request is taken meanwhile; the capacity resets to 100.
// A finished result waits in an output register; the next request is taken
// meanwhile, and its result waits until the receiver takes the earlier one.
module duplicate_packet_filter_core #(
	parameter int CHANNELS = dpf_pkg::DEFAULT_CHANNELS,
	parameter int DEPTH    = dpf_pkg::DEFAULT_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [dpf_pkg::CAP_W-1:0]  cfg_wdata,
	dpf_pkt_if.sink                    pkt,
	dpf_res_if.source                  res
);
	import dpf_pkg::*;

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int FW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(CHANNELS * DEPTH);
	localparam int TW = 1 + RATE_W + FW;
	localparam int EW = $bits(entry_t);

	logic [CAP_W-1:0] cap_q;
	logic [FW-1:0]    cap;
	logic [CW-1:0]    ch_idx;
	logic             ent_we;
	logic [AW-1:0]    ent_waddr;
	entry_t           ent_wdata;
	logic [AW-1:0]    ent_raddr;
	entry_t           ent_rdata;
	logic [EW-1:0]    ent_rbits;
	logic             chn_we;
	logic [CW-1:0]    chn_waddr;
	logic [TW-1:0]    chn_wdata;
	logic [CW-1:0]    chn_raddr;
	logic [TW-1:0]    chn_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// zero acts as one, above DEPTH as DEPTH
	always_comb begin
		if (cap_q == '0) cap = FW'(1);
		else if (32'(cap_q) > 32'(DEPTH)) cap = FW'(DEPTH);
		else cap = FW'(cap_q);
	end

	always_comb begin
		ch_idx = '0;
		for (int k = 0; k < (1 << CHAN_W); k++) begin
			if (pkt.channel == CHAN_W'(k)) ch_idx = CW'(k % CHANNELS);
		end
	end

	assign ent_rdata = entry_t'(ent_rbits);

	dpf_ctrl #(
		.CHANNELS(CHANNELS), .DEPTH(DEPTH), .CW(CW), .FW(FW), .AW(AW), .TW(TW)
	) u_ctrl (
		.clk, .arst_n, .cap, .ch_idx, .pkt, .res,
		.ent_we, .ent_waddr, .ent_wdata, .ent_raddr, .ent_rdata,
		.chn_we, .chn_waddr, .chn_wdata, .chn_raddr, .chn_rdata
	);

	dpf_ram #(.WIDTH(EW), .WORDS(CHANNELS * DEPTH), .ADDR_W(AW)) u_entry_ram (
		.clk, .we(ent_we), .waddr(ent_waddr), .wdata(EW'(ent_wdata)),
		.raddr(ent_raddr), .rdata(ent_rbits)
	);

	dpf_ram #(.WIDTH(TW), .WORDS(CHANNELS), .ADDR_W(CW)) u_chan_ram (
		.clk, .we(chn_we), .waddr(chn_waddr), .wdata(chn_wdata),
		.raddr(chn_raddr), .rdata(chn_rdata)
	);
endmodule

// ===== bench/dpf_checker.sv =====
// checker: predicts filter decisions from observed requests and compares results
module dpf_checker (
	input  logic       clk,
	input  logic [7:0] capacity,
	dpf_pkt_if         pkt,
	dpf_res_if         res,
	output int         errors,
	output int         pending
);
	import dpf_pkg::*;

	localparam int NCH = 64;
	localparam int NDP = 128;

	typedef struct {
		logic    allowed;
		status_t status;
	} verdict_t;

	entry_t     rows[NCH][$];
	logic [15:0] ch_rate[NCH];
	bit         ch_seen[NCH];
	verdict_t   verdicts[$];

	initial begin
		errors = 0;
		foreach (ch_seen[i]) ch_seen[i] = 0;
	end

	assign pending = verdicts.size();

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic logic [63:0] tol_of(input logic [15:0] r);
		if (r < 16'd105) return 64'd15000;
		if (r < 16'd255) return 64'd4500;
		if (r < 16'd505) return 64'd2500;
		if (r < 16'd1005) return 64'd1500;
		return 64'd0;
	endfunction

	function automatic verdict_t judge(input logic [5:0] ch, input logic [61:0] st,
		input logic [61:0] en, input logic [15:0] rate, input logic [15:0] cnt);
		verdict_t v;
		int cap;
		int pos;
		logic [63:0] tol;
		logic [63:0] d;
		entry_t e;
		entry_t key;
		cap = int'(capacity);
		if (cap < 1) cap = 1;
		if (cap > NDP) cap = NDP;
		e.t_start = st;
		e.t_end = en;
		e.samples = cnt;
		if (cnt == 0) begin
			v.allowed = 0; v.status = STS_EMPTY; return v;
		end
		if (!ch_seen[ch]) begin
			ch_seen[ch] = 1;
			ch_rate[ch] = rate;
			rows[ch] = {e};
			v.allowed = 1; v.status = STS_FIRST; return v;
		end
		if (rate != ch_rate[ch]) begin
			v.allowed = 1; v.status = STS_MISMATCH; return v;
		end
		tol = tol_of(rate);
		foreach (rows[ch][i]) begin
			if (rows[ch][i].samples == cnt) begin
				d = rows[ch][i].t_start > st ? 64'(rows[ch][i].t_start - st)
					: 64'(st - rows[ch][i].t_start);
				if (tol == 0) begin
					v.allowed = 1; v.status = STS_UNCLASS; return v;
				end
				if (d < tol) begin
					v.allowed = 0; v.status = STS_DUPLICATE; return v;
				end
			end
		end
		if (rows[ch].size() == 0 || st > rows[ch][$].t_end) begin
			while (rows[ch].size() >= cap) void'(rows[ch].pop_front());
			rows[ch].insert(rows[ch].size(), e);
			v.allowed = 1; v.status = STS_APPENDED; return v;
		end
		if (en < rows[ch][0].t_start) begin
			v.allowed = 1;
			if (rows[ch].size() < cap) begin
				rows[ch].insert(0, e);
				v.status = STS_PREPENDED;
			end else
				v.status = STS_TOO_OLD;
			return v;
		end
		foreach (rows[ch][i]) begin
			if ((st >= rows[ch][i].t_start && st <= rows[ch][i].t_end) ||
				(en >= rows[ch][i].t_start && en <= rows[ch][i].t_end)) begin
				v.allowed = 0; v.status = STS_SLIP; return v;
			end
		end
		while (rows[ch].size() >= cap) void'(rows[ch].pop_front());
		// stable insertion sort of the whole row
		rows[ch].insert(rows[ch].size(), e);
		for (int i = 1; i < rows[ch].size(); i++) begin
			key = rows[ch][i];
			pos = i;
			while (pos > 0 && rows[ch][pos-1].t_start > key.t_start) begin
				rows[ch][pos] = rows[ch][pos-1];
				pos--;
			end
			rows[ch][pos] = key;
		end
		v.allowed = 1; v.status = STS_BACKFILL;
		return v;
	endfunction

	always @(posedge clk) begin
		verdict_t exp_v;
		if (pkt.valid === 1'b1 && pkt.ready === 1'b1)
			verdicts.insert(verdicts.size(), judge(pkt.channel, pkt.start_time,
				pkt.end_time, pkt.sample_rate, pkt.sample_count));
		if (res.valid === 1'b1 && res.ready === 1'b1) begin
			if (verdicts.size() == 0)
				report("result with no request outstanding");
			else begin
				exp_v = verdicts.pop_front();
				if (res.allowed !== exp_v.allowed)
					report($sformatf("allowed %b, expected %b", res.allowed, exp_v.allowed));
				if (res.status !== exp_v.status)
					report($sformatf("status %0d, expected %0d", res.status, exp_v.status));
			end
		end
	end
endmodule

// ===== bench/duplicate_packet_filter_core_tb.sv =====
// testbench top: clock, reset, request stimulus, capacity phases and verdict
module duplicate_packet_filter_core_tb;
	import dpf_pkg::*;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       cfg_we = 0;
	logic [7:0] cfg_wdata = '0;
	logic [7:0] capacity = 8'd100;
	int         errors;
	int         pending;
	int         cycles = 0;
	bit         no_idle = 0;
	bit         hold_off = 0;

	logic [61:0] next_t[64];
	logic [15:0] ch_rate[64];

	dpf_pkt_if pkt();
	dpf_res_if res();

	duplicate_packet_filter_core i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.pkt(pkt), .res(res)
	);

	dpf_checker i_check (
		.clk(clk), .capacity(capacity), .pkt(pkt), .res(res),
		.errors(errors), .pending(pending)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > 10000000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		res.ready = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				res.ready <= 0;
				repeat (3000) @(negedge clk);
				hold_off = 0;
			end else
				res.ready <= no_idle || $urandom_range(99) >= 7;
		end
	end

	task automatic send(input logic [5:0] ch, input logic [61:0] st, input logic [61:0] en,
		input logic [15:0] rate, input logic [15:0] cnt);
		while (!no_idle && $urandom_range(99) < 7) begin
			pkt.valid <= 0;
			@(negedge clk);
		end
		pkt.valid <= 1;
		pkt.channel <= ch;
		pkt.start_time <= st;
		pkt.end_time <= en;
		pkt.sample_rate <= rate;
		pkt.sample_count <= cnt;
		do @(posedge clk); while (!(pkt.ready === 1'b1));
		@(negedge clk);
	endtask

	task automatic write_cap(input logic [7:0] v);
		pkt.valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (40000) @(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		capacity = v;
	endtask

	// mostly well-formed streams per channel with occasional broken ones
	task automatic random_item(input int nch);
		logic [5:0] ch;
		logic [61:0] st;
		logic [61:0] len;
		logic [15:0] cnt;
		int k;
		ch = 6'($urandom_range(nch - 1));
		len = 62'($urandom_range(5000, 1));
		cnt = $urandom_range(4) == 0 ? 16'($urandom) : 16'($urandom_range(4, 1));
		k = $urandom_range(99);
		if (k < 55) begin
			st = next_t[ch] + 62'($urandom_range(3000, 1));
			next_t[ch] = st + len;
		end else if (k < 75)
			st = next_t[ch] - 62'($urandom_range(60000));
		else if (k < 80)
			st = 62'({$urandom, $urandom});
		else if (k < 88)
			st = next_t[ch] - 62'($urandom_range(800000, 100000));
		else
			st = next_t[ch] - 62'($urandom_range(20000));
		if (k >= 96) cnt = 0;
		send(ch, st, st + len, k == 97 ? 16'($urandom) : ch_rate[ch], cnt);
	endtask

	initial begin
		logic [61:0] top;
		pkt.valid = 0;
		pkt.channel = '0;
		pkt.start_time = '0;
		pkt.end_time = '0;
		pkt.sample_rate = '0;
		pkt.sample_count = '0;
		top = '1;
		foreach (next_t[i]) begin
			next_t[i] = 62'd1000000 * 62'(i + 1);
			case (i % 5)
				0: ch_rate[i] = 16'($urandom_range(104));
				1: ch_rate[i] = 16'($urandom_range(254, 105));
				2: ch_rate[i] = 16'($urandom_range(504, 255));
				3: ch_rate[i] = 16'($urandom_range(1004, 505));
				default: ch_rate[i] = 16'($urandom_range(65535, 1005));
			endcase
		end
		repeat (7) @(negedge clk);
		arst_n = 1;

		// directed
		send(6'd0, 62'd1000, 62'd2000, 16'd0, 16'd0);
		send(6'd63, top - 10, top, 16'hffff, 16'hffff);
		send(6'd63, top - 10, top, 16'hffff, 16'hffff);
		send(6'd63, 62'd5, 62'd9, 16'hffff, 16'd3);
		send(6'd0, 62'd100000, 62'd101000, 16'd40, 16'd10);
		send(6'd0, 62'd100000, 62'd101000, 16'd41, 16'd10);
		send(6'd0, 62'd110000, 62'd111000, 16'd40, 16'd10);
		send(6'd0, 62'd200000, 62'd201000, 16'd40, 16'd10);
		send(6'd0, 62'd50000, 62'd60000, 16'd40, 16'd11);
		send(6'd0, 62'd150000, 62'd160000, 16'd40, 16'd12);
		send(6'd0, 62'd150500, 62'd170000, 16'd40, 16'd13);
		send(6'd0, 62'd40000, 62'd55000, 16'd40, 16'd14);
		send(6'd0, 62'd150000, 62'd150000, 16'd40, 16'd15);
		send(6'd1, 62'd0, 62'd0, 16'd2000, 16'd7);
		send(6'd1, 62'd10, 62'd20, 16'd2000, 16'd8);
		send(6'd1, 62'd30, 62'd40, 16'd2000, 16'd7);
		send(6'd2, 62'd1000, 62'd1500, 16'd300, 16'd9);
		send(6'd2, 62'd3499, 62'd3600, 16'd300, 16'd9);
		send(6'd2, 62'd3500, 62'd3600, 16'd300, 16'd9);

		write_cap(8'd1);
		send(6'd2, 62'd1, 62'd2, 16'd300, 16'd20);
		send(6'd2, 62'd9000, 62'd9100, 16'd300, 16'd21);
		send(6'd2, 62'd5000, 62'd5100, 16'd300, 16'd22);

		write_cap(8'd0);
		no_idle = 1;
		repeat (150) random_item(8);
		no_idle = 0;

		write_cap(8'd3);
		repeat (250) random_item(8);
		hold_off = 1;
		repeat (20) random_item(8);

		write_cap(8'd255);
		repeat (150) random_item(4);

		write_cap(8'd128);
		repeat (300) random_item(64);

		write_cap(8'd6);
		repeat (330) random_item(16);

		pkt.valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (40000) @(negedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ===== filelist.f =====
hdl/dpf_pkg.sv
hdl/dpf_if.sv
hdl/dpf_ram.sv
hdl/dpf_ctrl.sv
hdl/duplicate_packet_filter_core.sv
bench/dpf_checker.sv
bench/duplicate_packet_filter_core_tb.sv
